// File: rtl/setm_pkg.sv
// shared exponent tone mapper package: formats, register codes, shared types
// no dependencies
package setm_pkg;
  localparam int VALUE_FRAC_BITS = 24;
  localparam int VALUE_INT_BITS  = 24;
  localparam int VW   = VALUE_FRAC_BITS + VALUE_INT_BITS;
  localparam int PW   = 32;
  localparam int QB   = 8;
  localparam int EXP_BIAS  = 136;
  localparam int GAIN_FRAC = 16;
  localparam int SOFF = GAIN_FRAC + EXP_BIAS - VALUE_FRAC_BITS;
  localparam int SW   = 10;
  localparam int NCH  = 3;
  localparam int QDEPTH = 2;

  typedef enum logic [0:0] {
    REG_EXPOSURE = 1'b0,
    REG_TONE     = 1'b1
  } reg_idx_t;

  // pixel in value format, three channels, handed from front to back
  typedef struct packed {
    logic [NCH-1:0][VW-1:0] val;
  } value_item_t;

  // front end stage status: valid flag of each register
  typedef struct packed {
    logic mul_vld;
    logic val_vld;
  } front_stat_t;
endpackage

// File: rtl/setm_front.sv
// front end: exposure product and shift into saturating value format
// depends on setm_pkg
module setm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                red_mantissa,
  input  logic [7:0]                green_mantissa,
  input  logic [7:0]                blue_mantissa,
  input  logic [7:0]                shared_exponent,
  input  logic [23:0]               exposure_gain,
  output logic                      f_valid,
  input  logic                      f_stall,
  output setm_pkg::value_item_t     f_item,
  output setm_pkg::front_stat_t     f_stat
);
  logic [setm_pkg::NCH-1:0][setm_pkg::PW-1:0] prod_r, prod_nxt;
  logic [7:0]  exp_r;
  logic        mul_vld_r, val_vld_r;
  setm_pkg::value_item_t val_r, val_nxt;
  logic adv_val, adv_mul;
  logic [setm_pkg::NCH-1:0][7:0] man;
  logic signed [setm_pkg::SW-1:0] sh;
  logic signed [setm_pkg::SW-1:0] nsh;
  logic [setm_pkg::SW-2:0] rsh;
  logic [setm_pkg::PW+setm_pkg::VW-1:0] wide;
  localparam logic [setm_pkg::VW-1:0] MAXV = '1;

  assign man = {blue_mantissa, green_mantissa, red_mantissa};
  assign adv_val = !val_vld_r || !f_stall;
  assign adv_mul = !mul_vld_r || adv_val;
  assign in_stall = !adv_mul;

  always_comb begin
    for (int c = 0; c < setm_pkg::NCH; c++) begin
      prod_nxt[c] = setm_pkg::PW'({24'd0, man[c]} * {8'd0, exposure_gain});
    end
  end

  always_comb begin
    sh = setm_pkg::SW'($signed({2'b00, exp_r})) - setm_pkg::SW'(setm_pkg::SOFF);
    nsh = -sh;
    rsh = nsh[setm_pkg::SW-2:0];
    val_nxt = '0;
    wide = '0;
    for (int c = 0; c < setm_pkg::NCH; c++) begin
      if (sh < 0) begin
        if (rsh >= setm_pkg::PW) val_nxt.val[c] = '0;
        else begin
          wide = (setm_pkg::PW+setm_pkg::VW)'(prod_r[c]) >> rsh;
          val_nxt.val[c] = (wide > (setm_pkg::PW+setm_pkg::VW)'(MAXV)) ? MAXV
                                                                       : wide[setm_pkg::VW-1:0];
        end
      end else if (prod_r[c] == '0) val_nxt.val[c] = '0;
      else if (sh >= setm_pkg::VW) val_nxt.val[c] = MAXV;
      else begin
        wide = (setm_pkg::PW+setm_pkg::VW)'(prod_r[c]) << sh[setm_pkg::SW-2:0];
        val_nxt.val[c] = (wide > (setm_pkg::PW+setm_pkg::VW)'(MAXV)) ? MAXV
                                                                     : wide[setm_pkg::VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      val_vld_r <= 1'b0;
    end else begin
      if (adv_mul) mul_vld_r <= in_valid;
      if (adv_val) val_vld_r <= mul_vld_r;
    end
    if (adv_mul) begin
      prod_r <= prod_nxt;
      exp_r  <= shared_exponent;
    end
    if (adv_val) val_r <= val_nxt;
  end

  assign f_valid = val_vld_r;
  assign f_item  = val_r;
  assign f_stat  = '{mul_vld: mul_vld_r, val_vld: val_vld_r};

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    val_vld_r && f_stall |=> val_vld_r && $stable(val_r))
    else $error("front output changed under stall");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> mul_vld_r)
    else $error("accepted pixel lost in front");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> mul_vld_r && val_vld_r)
    else $error("front stalled while not full");
`endif
endmodule

// File: rtl/setm_queue.sv
// short queue between front and back end
// depends on setm_pkg
module setm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  w_valid,
  output logic                  w_stall,
  input  setm_pkg::value_item_t w_item,
  output logic                  r_valid,
  input  logic                  r_stall,
  output setm_pkg::value_item_t r_item
);
  setm_pkg::value_item_t mem_r [setm_pkg::QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign w_stall = (cnt_r == 2'd2);
  assign r_valid = (cnt_r != 2'd0);
  assign r_item  = mem_r[rp_r];
  assign wr = w_valid && !w_stall;
  assign rd = r_valid && !r_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= w_item;
  end

`ifndef NO_ASSERTIONS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers inconsistent");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count not bumped");
`endif
endmodule

// File: rtl/setm_div.sv
// back end: pipelined restoring divider, one quotient bit per stage
// computes floor(255*v/(v+k)) for three channels; depends on setm_pkg
module setm_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  b_valid,
  output logic                  b_stall,
  input  setm_pkg::value_item_t b_item,
  input  logic [23:0]           tone_constant,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out
);
  localparam int VW = setm_pkg::VW;
  localparam int NW = VW + 8;
  localparam int DW = VW + 1;
  localparam int NS = setm_pkg::QB + 1;

  // stage 0 forms numerator and denominator; stages 1..8 each settle one quotient bit
  logic [NS-1:0] vld_r;
  logic [NS-1:0][setm_pkg::NCH-1:0][NW-1:0] rem_r;
  logic [NS-1:0][setm_pkg::NCH-1:0][DW-1:0] den_r;
  logic [NS-1:0][setm_pkg::NCH-1:0][7:0] q_r;
  logic [NS-1:0] adv;
  logic [DW-1:0] kval;

  assign kval = DW'(tone_constant) << (setm_pkg::VALUE_FRAC_BITS - setm_pkg::GAIN_FRAC);

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int s = NS-2; s >= 0; s--) adv[s] = !vld_r[s] || adv[s+1];
  end
  assign b_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else begin
      if (adv[0]) vld_r[0] <= b_valid;
      for (int s = 1; s < NS; s++) if (adv[s]) vld_r[s] <= vld_r[s-1];
    end
    if (adv[0]) begin
      for (int c = 0; c < setm_pkg::NCH; c++) begin
        rem_r[0][c] <= (NW'(b_item.val[c]) << 8) - NW'(b_item.val[c]);
        den_r[0][c] <= DW'(b_item.val[c]) + kval;
        q_r[0][c]   <= '0;
      end
    end
    for (int s = 1; s < NS; s++) begin
      if (adv[s]) begin
        for (int c = 0; c < setm_pkg::NCH; c++) begin
          den_r[s][c] <= den_r[s-1][c];
          if (den_r[s-1][c] != '0 &&
              (NW+8)'(rem_r[s-1][c]) >= ((NW+8)'(den_r[s-1][c]) << (NS-1-s))) begin
            rem_r[s][c] <= rem_r[s-1][c] - NW'((NW+8)'(den_r[s-1][c]) << (NS-1-s));
            q_r[s][c]   <= q_r[s-1][c] | (8'd1 << (NS-1-s));
          end else begin
            rem_r[s][c] <= rem_r[s-1][c];
            q_r[s][c]   <= q_r[s-1][c];
          end
        end
      end
    end
  end

  // a zero denominator never sets a quotient bit, so 0 over 0 gives 0
  assign out_valid = vld_r[NS-1];
  assign red_out   = q_r[NS-1][0];
  assign green_out = q_r[NS-1][1];
  assign blue_out  = q_r[NS-1][2];

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(red_out))
    else $error("result changed under stall");
  a_bstall: assert property (@(posedge clk) disable iff (!rst_n)
    b_stall |-> (&vld_r))
    else $error("back end stalled while not full");
`endif
endmodule

// File: rtl/shared_exponent_tone_mapper.sv
// path: front end product and value registers, then the queue, then the divider pipeline
// throughput: one pixel per clock while out_stall is low; the back end settles one quotient bit per stage
// a two-entry queue between front and back lets either side stall alone
// synchronous active-low reset clears valid flags; registers reset to 1.0 and 19661
// top level: config registers, front end, queue, divider; depends on setm_pkg
module shared_exponent_tone_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_mantissa,
  input  logic [7:0]  in_green_mantissa,
  input  logic [7:0]  in_blue_mantissa,
  input  logic [7:0]  in_shared_exponent,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out
);
  logic [23:0] gain_r, tone_r;
  logic f_valid, f_stall, q_valid, q_stall;
  setm_pkg::value_item_t f_item, q_item;
  setm_pkg::front_stat_t f_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 24'd65536;
      tone_r <= 24'd19661;
    end else if (cfg_valid) begin
      case (cfg_index)
        setm_pkg::REG_EXPOSURE: gain_r <= cfg_data;
        setm_pkg::REG_TONE:     tone_r <= cfg_data;
        default: ;
      endcase
    end
  end

  setm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .red_mantissa(in_red_mantissa), .green_mantissa(in_green_mantissa),
    .blue_mantissa(in_blue_mantissa), .shared_exponent(in_shared_exponent),
    .exposure_gain(gain_r),
    .f_valid, .f_stall, .f_item, .f_stat
  );

  setm_queue u_queue (
    .clk, .rst_n, .w_valid(f_valid), .w_stall(f_stall), .w_item(f_item),
    .r_valid(q_valid), .r_stall(q_stall), .r_item(q_item)
  );

  setm_div u_div (
    .clk, .rst_n, .b_valid(q_valid), .b_stall(q_stall), .b_item(q_item),
    .tone_constant(tone_r), .out_valid, .out_stall,
    .red_out(out_red_out), .green_out(out_green_out), .blue_out(out_blue_out)
  );

`ifndef NO_ASSERTIONS
  a_front_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> f_stat.mul_vld && f_stat.val_vld && f_stall)
    else $error("input stalled with room in front end");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index == setm_pkg::REG_TONE |=> tone_r == $past(cfg_data))
    else $error("tone constant write lost");
`endif
endmodule
